FILE: rtl/olst_pkg.sv
package olst_pkg;

    typedef enum logic [1:0] {
        REQ_INS_FRONT = 2'd0,
        REQ_INS_BACK  = 2'd1,
        REQ_REMOVE    = 2'd2,
        REQ_DUMP      = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_ELEMENT   = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        req_type_t          req_type;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] element;
        logic               last;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    wr_front;
        logic    wr_back;
        logic    idx_inc;
        logic    rd_en;
        logic    rd_nxt;
        logic    sh_wr;
        logic    cnt_dec;
        logic    emit;
        status_t emit_status;
        logic    emit_elem;
        logic    emit_last;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        req_type_t req_type;
        logic      count_zero;
        logic      full;
        logic      idx_last;
        logic      next_last;
        logic      match;
        logic      out_free;
    } stat_t;

endpackage

FILE: rtl/ordered_list_store.sv
// Insert: the request is accepted in idle, then dispatched, and the result is registered; no new
// request is taken until the controller is back in idle. Remove: dispatch, a read and a compare per
// entry compared, a read and a write per entry shifted, then the result (at dispatch if empty).
// Dump: dispatch, then a read and an output per element; an empty list is answered at dispatch.
// A result still held by the receiver stalls the controller until it is taken.
// Reset (synchronous, active low) empties the list at once; stored values are not cleared.
module ordered_list_store #(
    parameter int CAPACITY = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  olst_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output olst_pkg::rsp_t m_data
);

    olst_pkg::cmd_t  cmd;
    olst_pkg::stat_t stat;

    olst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    olst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/olst_dp.sv
module olst_dp #(
    parameter int CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  olst_pkg::req_t   s_data,
    input  olst_pkg::cmd_t   cmd,
    output olst_pkg::stat_t  stat,
    output logic             m_valid,
    input  logic             m_ready,
    output olst_pkg::rsp_t   m_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW:0] CAP_X = (IW + 1)'(CAPACITY);

    logic [31:0] mem [CAPACITY];

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    olst_pkg::req_type_t req_type_reg;
    logic [31:0] value_reg;
    logic [31:0] rdata_reg;
    logic m_valid_reg, m_valid_next;
    olst_pkg::rsp_t m_data_reg, m_data_next;

    logic [IW:0]   cur_sum, nxt_sum, back_sum;
    logic [IW-1:0] cur_addr, nxt_addr, back_addr, front_addr, rd_addr, wr_addr;
    logic [31:0]   wr_data;
    logic          wr_en;
    logic          out_free;

    // Logical position to physical slot in the circular store.
    always_comb begin
        cur_sum  = {1'b0, head_reg} + {1'b0, idx_reg};
        nxt_sum  = {1'b0, head_reg} + {1'b0, idx_reg} + (IW + 1)'(1);
        back_sum = {1'b0, head_reg} + (IW + 1)'(count_reg);
        cur_addr  = (cur_sum >= CAP_X) ? IW'(cur_sum - CAP_X) : cur_sum[IW-1:0];
        nxt_addr  = (nxt_sum >= CAP_X) ? IW'(nxt_sum - CAP_X) : nxt_sum[IW-1:0];
        back_addr = (back_sum >= CAP_X) ? IW'(back_sum - CAP_X) : back_sum[IW-1:0];
        front_addr = (head_reg == '0) ? IW'(CAPACITY - 1) : head_reg - IW'(1);
        rd_addr = cmd.rd_nxt ? nxt_addr : cur_addr;
    end

    always_comb begin
        wr_en   = cmd.wr_front | cmd.wr_back | cmd.sh_wr;
        wr_addr = cur_addr;
        wr_data = rdata_reg;
        if (cmd.wr_front) begin
            wr_addr = front_addr;
            wr_data = value_reg;
        end else if (cmd.wr_back) begin
            wr_addr = back_addr;
            wr_data = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.load) begin
            req_type_reg <= s_data.req_type;
            value_reg    <= s_data.value;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        head_next  = cmd.wr_front ? front_addr : head_reg;
        count_next = count_reg;
        if (cmd.wr_front || cmd.wr_back) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
        idx_next = idx_reg;
        if (cmd.load) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IW'(1);
        end
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.emit) begin
            m_valid_next        = 1'b1;
            m_data_next.status  = cmd.emit_status;
            m_data_next.element = cmd.emit_elem ? rdata_reg : '0;
            m_data_next.last    = cmd.emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_comb begin
        stat.req_type   = req_type_reg;
        stat.count_zero = (count_reg == '0);
        stat.full       = (count_reg == CW'(CAPACITY));
        stat.idx_last   = ((CW + 1)'(idx_reg) + (CW + 1)'(1)) == (CW + 1)'(count_reg);
        stat.next_last  = ((CW + 1)'(idx_reg) + (CW + 1)'(2)) == (CW + 1)'(count_reg);
        stat.match      = (rdata_reg == value_reg);
        stat.out_free   = out_free;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < IW'(CAPACITY - 1) || head_reg == IW'(CAPACITY - 1))
        else $error("head pointer out of range");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("result register overwritten before it was taken");

    a_ins_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_front || cmd.wr_back) |-> count_reg != CW'(CAPACITY))
        else $error("insert into a full list");

endmodule

FILE: rtl/olst_ctrl.sv
module olst_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  olst_pkg::stat_t stat,
    output olst_pkg::cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DISPATCH = 10'b00_0000_0010,
        S_RM_RD    = 10'b00_0000_0100,
        S_RM_CMP   = 10'b00_0000_1000,
        S_SH_RD    = 10'b00_0001_0000,
        S_SH_WR    = 10'b00_0010_0000,
        S_RM_DONE  = 10'b00_0100_0000,
        S_RM_MISS  = 10'b00_1000_0000,
        S_D_RD     = 10'b01_0000_0000,
        S_D_OUT    = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_status = olst_pkg::ST_DONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.out_free) begin
                    unique case (stat.req_type)
                        olst_pkg::REQ_INS_FRONT, olst_pkg::REQ_INS_BACK: begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            if (stat.full) begin
                                cmd.emit_status = olst_pkg::ST_FULL;
                            end else begin
                                cmd.wr_front = (stat.req_type == olst_pkg::REQ_INS_FRONT);
                                cmd.wr_back  = (stat.req_type == olst_pkg::REQ_INS_BACK);
                            end
                            state_next = S_IDLE;
                        end
                        olst_pkg::REQ_REMOVE: begin
                            if (stat.count_zero) begin
                                cmd.emit        = 1'b1;
                                cmd.emit_last   = 1'b1;
                                cmd.emit_status = olst_pkg::ST_NOT_FOUND;
                                state_next      = S_IDLE;
                            end else begin
                                state_next = S_RM_RD;
                            end
                        end
                        olst_pkg::REQ_DUMP: begin
                            if (stat.count_zero) begin
                                cmd.emit        = 1'b1;
                                cmd.emit_last   = 1'b1;
                                cmd.emit_status = olst_pkg::ST_EMPTY;
                                state_next      = S_IDLE;
                            end else begin
                                state_next = S_D_RD;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RM_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_RM_CMP;
            end
            S_RM_CMP: begin
                if (stat.match) begin
                    state_next = stat.idx_last ? S_RM_DONE : S_SH_RD;
                end else if (stat.idx_last) begin
                    state_next = S_RM_MISS;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RM_RD;
                end
            end
            S_SH_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_nxt = 1'b1;
                state_next = S_SH_WR;
            end
            S_SH_WR: begin
                // Move the following entry up one place to close the gap.
                cmd.sh_wr   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = stat.next_last ? S_RM_DONE : S_SH_RD;
            end
            S_RM_DONE: begin
                if (stat.out_free) begin
                    cmd.cnt_dec   = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RM_MISS: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = olst_pkg::ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
            end
            S_D_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_D_OUT;
            end
            S_D_OUT: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = olst_pkg::ST_ELEMENT;
                    cmd.emit_elem   = 1'b1;
                    cmd.emit_last   = stat.idx_last;
                    if (stat.idx_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_D_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_emit_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.emit_last) |=> state_reg == S_IDLE)
        else $error("final result emitted without returning to idle");

    a_load_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_DISPATCH)
        else $error("accepted request not dispatched");

    a_no_double_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.wr_front, cmd.wr_back, cmd.sh_wr}) <= 1)
        else $error("conflicting store writes");

endmodule

FILE: test/tb_ordered_list_store.sv
`timescale 1ns / 100ps

module tb_ordered_list_store;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    olst_pkg::req_t s_data;
    logic           m_valid;
    logic           m_ready;
    olst_pkg::rsp_t m_data;

    ordered_list_store #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow copy of the list, front at index 0, and the responses still owed.
    logic signed [31:0] list_model[$];
    olst_pkg::rsp_t     expected_rsp_q[$];

    int  error_count;
    int  cycle_count;
    int  receiver_hold_cycles;
    bit  sender_idle_on;
    bit  receiver_stall_on;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic olst_pkg::rsp_t make_rsp(olst_pkg::status_t status,
                                                logic signed [31:0] element, logic last);
        olst_pkg::rsp_t r;
        r.status  = status;
        r.element = element;
        r.last    = last;
        return r;
    endfunction

    // Applies one accepted request to the shadow list and queues its responses.
    task automatic predict_list_response(input olst_pkg::req_t req);
        int idx;
        int n;
        idx = -1;
        n   = list_model.size();
        case (req.req_type)
            olst_pkg::REQ_INS_FRONT, olst_pkg::REQ_INS_BACK: begin
                if (n >= CAPACITY) begin
                    expected_rsp_q.push_back(make_rsp(olst_pkg::ST_FULL, '0, 1'b1));
                end else begin
                    if (req.req_type == olst_pkg::REQ_INS_FRONT) begin
                        list_model.push_front(req.value);
                    end else begin
                        list_model.push_back(req.value);
                    end
                    expected_rsp_q.push_back(make_rsp(olst_pkg::ST_DONE, '0, 1'b1));
                end
            end
            olst_pkg::REQ_REMOVE: begin
                for (int i = 0; i < n; i++) begin
                    if (idx < 0 && list_model[i] == req.value) begin
                        idx = i;
                    end
                end
                if (idx < 0) begin
                    expected_rsp_q.push_back(make_rsp(olst_pkg::ST_NOT_FOUND, '0, 1'b1));
                end else begin
                    list_model.delete(idx);
                    expected_rsp_q.push_back(make_rsp(olst_pkg::ST_DONE, '0, 1'b1));
                end
            end
            default: begin
                if (n == 0) begin
                    expected_rsp_q.push_back(make_rsp(olst_pkg::ST_EMPTY, '0, 1'b1));
                end else begin
                    for (int i = 0; i < n; i++) begin
                        expected_rsp_q.push_back(make_rsp(olst_pkg::ST_ELEMENT, list_model[i],
                                                          i == n - 1));
                    end
                end
            end
        endcase
    endtask

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_request(input olst_pkg::req_type_t kind,
                                input logic signed [31:0] value);
        int gap;
        olst_pkg::req_t req;
        gap          = sender_idle_on ? $urandom_range(0, 16) : 0;
        req.req_type = kind;
        req.value    = value;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_list_response(req);
    endtask

    // Result side: a random stall before each transaction, or a long hold when asked.
    initial begin
        int wait_cycles;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (receiver_hold_cycles > 0) begin
                wait_cycles = receiver_hold_cycles;
                receiver_hold_cycles = 0;
            end else begin
                wait_cycles = receiver_stall_on ? $urandom_range(0, 16) : 0;
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        olst_pkg::rsp_t exp_rsp;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp_q.size() == 0) begin
                if (error_count < MAX_REPORTS) begin
                    $display("unexpected result: status %0d element %h last %b",
                             m_data.status, m_data.element, m_data.last);
                end
                error_count++;
            end else begin
                exp_rsp = expected_rsp_q.pop_front();
                if (m_data.status !== exp_rsp.status || m_data.element !== exp_rsp.element
                        || m_data.last !== exp_rsp.last) begin
                    if (error_count < MAX_REPORTS) begin
                        $display({"mismatch: status exp %0d got %0d, ",
                                  "element exp %h got %h, last exp %b got %b"},
                                 exp_rsp.status, m_data.status, exp_rsp.element,
                                 m_data.element, exp_rsp.last, m_data.last);
                    end
                    error_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] draw_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
            return $urandom;
        end else if (pick <= 7) begin
            // A small pool so that duplicates and repeated removals happen often.
            return $signed($urandom_range(0, 7)) - 4;
        end else if (pick == 8) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end else if (list_model.size() > 0) begin
            return list_model[$urandom_range(0, list_model.size() - 1)];
        end
        return $urandom;
    endfunction

    task automatic test_empty_list();
        send_request(olst_pkg::REQ_DUMP, 32'sd0);
        send_request(olst_pkg::REQ_REMOVE, 32'sd0);
        send_request(olst_pkg::REQ_REMOVE, -32'sd1);
    endtask

    task automatic test_insert_extremes();
        send_request(olst_pkg::REQ_INS_FRONT, 32'sh8000_0000);
        send_request(olst_pkg::REQ_INS_BACK, 32'sh7FFF_FFFF);
        send_request(olst_pkg::REQ_INS_FRONT, 32'sh0000_0000);
        send_request(olst_pkg::REQ_INS_BACK, -32'sd1);
        send_request(olst_pkg::REQ_DUMP, 32'sh5A5A_A5A5);
    endtask

    task automatic test_remove_cases();
        // Differs from a stored value in a single bit, so it must not match.
        send_request(olst_pkg::REQ_REMOVE, 32'sh7FFF_FFFE);
        send_request(olst_pkg::REQ_INS_BACK, 32'sd5);
        send_request(olst_pkg::REQ_INS_FRONT, 32'sd5);
        // Only the first of the two equal entries goes.
        send_request(olst_pkg::REQ_REMOVE, 32'sd5);
        send_request(olst_pkg::REQ_REMOVE, 32'sh7FFF_FFFF);
        send_request(olst_pkg::REQ_REMOVE, -32'sd1);
        send_request(olst_pkg::REQ_DUMP, 32'sd0);
        send_request(olst_pkg::REQ_REMOVE, 32'sd0);
        send_request(olst_pkg::REQ_DUMP, 32'sd0);
    endtask

    // The result side holds off while the list is filled past its capacity.
    task automatic test_full_under_backpressure();
        olst_pkg::req_type_t kind;
        sender_idle_on       = 1'b0;
        receiver_hold_cycles = 300;
        while (list_model.size() < CAPACITY) begin
            if ($urandom_range(0, 1) != 0) begin
                kind = olst_pkg::REQ_INS_BACK;
            end else begin
                kind = olst_pkg::REQ_INS_FRONT;
            end
            send_request(kind, draw_value());
        end
        send_request(olst_pkg::REQ_INS_FRONT, 32'sd1);
        send_request(olst_pkg::REQ_INS_BACK, 32'sd2);
        send_request(olst_pkg::REQ_DUMP, 32'sd0);
        send_request(olst_pkg::REQ_REMOVE, list_model[CAPACITY - 1]);
        send_request(olst_pkg::REQ_REMOVE, list_model[0]);
        send_request(olst_pkg::REQ_DUMP, 32'sd0);
        sender_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic(input int n_items);
        int roll;
        bit growing;
        olst_pkg::req_type_t kind;
        logic signed [31:0] value;
        growing = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            // Cycle through the idling combinations in stretches.
            sender_idle_on    = ((k / 25) % 4) inside {0, 1};
            receiver_stall_on = ((k / 25) % 4) inside {0, 2};
            if (k % 18 == 17) begin
                growing = ~growing;
            end
            roll = $urandom_range(0, 99);
            if (growing) begin
                if (roll < 35) begin
                    kind = olst_pkg::REQ_INS_FRONT;
                end else if (roll < 70) begin
                    kind = olst_pkg::REQ_INS_BACK;
                end else if (roll < 85) begin
                    kind = olst_pkg::REQ_REMOVE;
                end else begin
                    kind = olst_pkg::REQ_DUMP;
                end
            end else begin
                if (roll < 10) begin
                    kind = olst_pkg::REQ_INS_FRONT;
                end else if (roll < 20) begin
                    kind = olst_pkg::REQ_INS_BACK;
                end else if (roll < 80) begin
                    kind = olst_pkg::REQ_REMOVE;
                end else begin
                    kind = olst_pkg::REQ_DUMP;
                end
            end
            if (kind == olst_pkg::REQ_REMOVE && list_model.size() > 0
                    && $urandom_range(0, 4) != 0) begin
                value = list_model[$urandom_range(0, list_model.size() - 1)];
            end else begin
                value = draw_value();
            end
            send_request(kind, value);
        end
        sender_idle_on    = 1'b1;
        receiver_stall_on = 1'b1;
    endtask

    initial begin
        s_valid              = 1'b0;
        s_data               = '0;
        aresetn              = 1'b0;
        error_count          = 0;
        cycle_count          = 0;
        receiver_hold_cycles = 0;
        sender_idle_on       = 1'b1;
        receiver_stall_on    = 1'b1;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_list();
        test_insert_extremes();
        test_remove_cases();
        test_full_under_backpressure();
        test_random_traffic(73);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0 && expected_rsp_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/olst_pkg.sv
rtl/olst_dp.sv
rtl/olst_ctrl.sv
rtl/ordered_list_store.sv
test/tb_ordered_list_store.sv
